[hw/rtl/rrf_pkg.sv]
// Shared types, constants and codes of the rational resampling FIR.
package rrf_pkg;

	localparam int MAX_TAPS     = 256;
	localparam int MAX_INTERP   = 16;
	localparam int SAMPLE_WIDTH = 32;
	localparam int COEF_WIDTH   = 24;
	localparam int COEF_FRAC    = COEF_WIDTH - 2;
	localparam int ACC_WIDTH    = 64;
	localparam int PROD_WIDTH   = SAMPLE_WIDTH + 1 + COEF_WIDTH;
	localparam int TAP_AW       = $clog2(MAX_TAPS);
	localparam int TAP_CW       = TAP_AW + 1;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 32;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_COEF  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} command_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INTERP = 3'd0,
		REG_DECIM  = 3'd1,
		REG_TAPS   = 3'd2,
		REG_WRAPEN = 3'd3,
		REG_WLOW   = 3'd4,
		REG_WHIGH  = 3'd5,
		REG_WSPAN  = 3'd6,
		REG_UNUSED = 3'd7
	} reg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIVLEN,
		ST_DIVPTR,
		ST_WRITE,
		ST_STEP,
		ST_SCAN,
		ST_MAC,
		ST_ROUND,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]                     command;
		logic signed [SAMPLE_WIDTH-1:0] sample_in;
		logic [7:0]                     coef_index;
		logic signed [COEF_WIDTH-1:0]   coef_value;
	} item_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample_out;
		logic                           last_of_run;
	} result_t;

endpackage

[hw/rtl/rrf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module rrf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[hw/rtl/rational_resampling_fir.sv]
// Top level of the polyphase rational resampling FIR with one shared multiply-accumulate unit.
// A push runs a restoring division for the ring length, then one for the pointer, writes the
// sample and walks the sub-steps. Each output reads ceil((tap_count - phase) / L) taps, and
// wrap correction adds a scan of the same taps. Coefficient writes and clears stay in idle.
// Reset clears control state and all history valid bits at once; coefficients are undefined
// until written. Outputs sit in a result register while the next item is taken.
module rational_resampling_fir (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               item_valid,
	output logic                               item_stall,
	input  rrf_pkg::item_t                     item,
	output logic                               result_valid,
	input  logic                               result_stall,
	output rrf_pkg::result_t                   result,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [rrf_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [rrf_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import rrf_pkg::*;

	logic [4:0]                     l_q;
	logic [6:0]                     m_q;
	logic [8:0]                     taps_q;
	logic                           wen_q;
	logic signed [SAMPLE_WIDTH-1:0] lo_q;
	logic signed [SAMPLE_WIDTH-1:0] hi_q;
	logic [30:0]                    span_q;

	logic [4:0]  l_eff;
	logic [6:0]  m_eff;
	logic [8:0]  taps_eff;

	state_t state_q, state_d;

	logic [TAP_AW-1:0]              ptr_q;
	logic [TAP_CW-1:0]              len_q;
	logic [MAX_TAPS-1:0]            hv_q;
	logic signed [SAMPLE_WIDTH-1:0] sample_q;
	logic [6:0]                     oph_q;
	logic [4:0]                     j_q;
	logic                           last_q;

	logic [8:0] div_n_q, div_d_q, quo_q;
	logic [9:0] rem_q;
	logic [3:0] cnt_q;
	logic [9:0] trial;
	logic       ge;
	logic [9:0] rem_n;
	logic [8:0] quo_n;
	logic [8:0] lenv;
	logic [8:0] p1;

	logic [TAP_CW-1:0]              tap_q;
	logic [TAP_AW-1:0]              rd_q;
	logic                           issue;
	logic                           rd_s1;
	logic                           hval_s1;
	logic                           pv_s2;
	logic [SAMPLE_WIDTH-1:0]        hist_rd;
	logic [COEF_WIDTH-1:0]          coef_rd;
	logic signed [SAMPLE_WIDTH-1:0] v32;
	logic signed [SAMPLE_WIDTH:0]   v33;
	logic                           below_q, above_q;
	logic signed [PROD_WIDTH-1:0]   prod_s2;
	logic signed [ACC_WIDTH-1:0]    acc_q;
	logic signed [ACC_WIDTH-1:0]    add_b;
	logic signed [ACC_WIDTH:0]      sum;
	logic signed [ACC_WIDTH-1:0]    sum_sat;
	logic signed [ACC_WIDTH-COEF_FRAC-1:0] qv;
	logic signed [SAMPLE_WIDTH-1:0] rnd_q;

	logic    accept;
	logic    out_load;
	result_t res_q;
	logic    res_valid_q;
	logic [7:0] jm;

	assign accept    = item_valid && !item_stall;
	assign item_stall = (state_q != ST_IDLE);
	assign cfg_ready  = 1'b1;

	assign l_eff    = (l_q == 5'd0) ? 5'd1 :
		(l_q > 5'(MAX_INTERP)) ? 5'(MAX_INTERP) : l_q;
	assign m_eff    = (m_q == 7'd0) ? 7'd1 : m_q;
	assign taps_eff = (taps_q == 9'd0) ? 9'd1 :
		(taps_q > 9'(MAX_TAPS)) ? 9'(MAX_TAPS) : taps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			l_q    <= 5'd1;
			m_q    <= 7'd1;
			taps_q <= 9'd1;
			wen_q  <= 1'b0;
			lo_q   <= '0;
			hi_q   <= '0;
			span_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (reg_index_t'(cfg_index))
				REG_INTERP: l_q    <= cfg_data[4:0];
				REG_DECIM:  m_q    <= cfg_data[6:0];
				REG_TAPS:   taps_q <= cfg_data[8:0];
				REG_WRAPEN: wen_q  <= cfg_data[0];
				REG_WLOW:   lo_q   <= cfg_data;
				REG_WHIGH:  hi_q   <= cfg_data;
				REG_WSPAN:  span_q <= cfg_data[30:0];
				REG_UNUSED: ;
			endcase
		end
	end

	// Restoring divider step, shared by the ring length and the pointer modulo.
	assign trial = {rem_q[8:0], div_n_q[8]};
	assign ge    = (trial >= {1'b0, div_d_q});
	assign rem_n = ge ? (trial - {1'b0, div_d_q}) : trial;
	assign quo_n = {quo_q[7:0], ge};
	assign lenv  = (quo_n == 9'd0) ? 9'd1 : quo_n;
	assign p1    = rem_n[8:0] + 9'd1;

	assign issue = ((state_q == ST_SCAN) || (state_q == ST_MAC)) && (tap_q < taps_eff);
	assign v32   = hval_s1 ? $signed(hist_rd) : '0;
	assign v33   = (below_q && above_q && (v32 < lo_q)) ?
		(SAMPLE_WIDTH+1)'(v32) + $signed({2'b00, span_q}) : (SAMPLE_WIDTH+1)'(v32);

	assign add_b   = (state_q == ST_ROUND) ? ACC_WIDTH'(64'sd1 <<< (COEF_FRAC - 1)) :
		ACC_WIDTH'(prod_s2);
	assign sum     = {acc_q[ACC_WIDTH-1], acc_q} + {add_b[ACC_WIDTH-1], add_b};
	assign sum_sat = (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) ?
		(sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}}) :
		sum[ACC_WIDTH-1:0];
	assign qv      = sum_sat[ACC_WIDTH-1:COEF_FRAC];
	assign jm      = 8'(j_q) + 8'(m_eff);
	assign out_load = (state_q == ST_EMIT) && (!res_valid_q || !result_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (command_t'(item.command) == CMD_PUSH)) begin
					state_d = ST_DIVLEN;
				end
			end
			ST_DIVLEN: begin
				if (cnt_q == 4'd8) begin
					state_d = ST_DIVPTR;
				end
			end
			ST_DIVPTR: begin
				if (cnt_q == 4'd8) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: state_d = ST_STEP;
			ST_STEP: begin
				if (j_q == l_eff) begin
					state_d = ST_IDLE;
				end else if (oph_q >= m_eff) begin
					state_d = wen_q ? ST_SCAN : ST_MAC;
				end
			end
			ST_SCAN: begin
				if (!issue && !rd_s1) begin
					state_d = ST_MAC;
				end
			end
			ST_MAC: begin
				if (!issue && !rd_s1 && !pv_s2) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_load) begin
					state_d = ST_STEP;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q   <= '0;
			hv_q    <= '0;
			oph_q   <= 7'd1;
			j_q     <= '0;
			rd_s1   <= 1'b0;
			pv_s2   <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			rd_s1 <= issue;
			pv_s2 <= rd_s1 && (state_q == ST_MAC);
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (command_t'(item.command) == CMD_CLEAR)) begin
						hv_q  <= '0;
						ptr_q <= '0;
						oph_q <= m_eff;
					end
				end
				ST_DIVPTR: begin
					if (cnt_q == 4'd8) begin
						ptr_q <= (p1 >= len_q) ? '0 : p1[TAP_AW-1:0];
					end
				end
				ST_WRITE: begin
					hv_q[ptr_q] <= 1'b1;
					j_q         <= '0;
				end
				ST_STEP: begin
					if (j_q != l_eff) begin
						if (oph_q >= m_eff) begin
							oph_q <= 7'd1;
						end else begin
							oph_q <= oph_q + 7'd1;
							j_q   <= j_q + 5'd1;
						end
					end
				end
				ST_EMIT: begin
					if (out_load) begin
						j_q <= j_q + 5'd1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		hval_s1 <= hv_q[rd_q];
		if (accept) begin
			sample_q <= item.sample_in;
			div_n_q  <= taps_eff;
			div_d_q  <= 9'(l_eff);
			rem_q    <= '0;
			quo_q    <= '0;
			cnt_q    <= '0;
		end
		if ((state_q == ST_DIVLEN) && (cnt_q == 4'd8)) begin
			len_q   <= lenv;
			div_n_q <= {1'b0, ptr_q};
			div_d_q <= lenv;
			rem_q   <= '0;
			quo_q   <= '0;
			cnt_q   <= '0;
		end else if ((state_q == ST_DIVLEN) || (state_q == ST_DIVPTR)) begin
			div_n_q <= {div_n_q[7:0], 1'b0};
			rem_q   <= rem_n;
			quo_q   <= quo_n;
			cnt_q   <= cnt_q + 4'd1;
		end
		if ((state_q == ST_STEP) && (j_q != l_eff) && (oph_q >= m_eff)) begin
			tap_q   <= TAP_CW'(j_q);
			rd_q    <= ptr_q;
			acc_q   <= '0;
			below_q <= 1'b0;
			above_q <= 1'b0;
			last_q  <= (jm >= 8'(l_eff));
		end
		if (issue) begin
			tap_q <= tap_q + TAP_CW'(l_eff);
			rd_q  <= (rd_q == '0) ? TAP_AW'(len_q - 9'd1) : rd_q - 1'b1;
		end
		if ((state_q == ST_SCAN) && rd_s1) begin
			if (v32 > hi_q) begin
				above_q <= 1'b1;
			end
			if (v32 < lo_q) begin
				below_q <= 1'b1;
			end
		end
		if ((state_q == ST_SCAN) && !issue && !rd_s1) begin
			tap_q <= TAP_CW'(j_q);
			rd_q  <= ptr_q;
		end
		if (rd_s1) begin
			prod_s2 <= v33 * $signed(coef_rd);
		end
		if (pv_s2) begin
			acc_q <= sum_sat;
		end
		if (state_q == ST_ROUND) begin
			if (!qv[ACC_WIDTH-COEF_FRAC-1] &&
				(qv[ACC_WIDTH-COEF_FRAC-1:SAMPLE_WIDTH-1] != '0)) begin
				rnd_q <= {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
			end else if (qv[ACC_WIDTH-COEF_FRAC-1] &&
				(qv[ACC_WIDTH-COEF_FRAC-1:SAMPLE_WIDTH-1] != '1)) begin
				rnd_q <= {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
			end else begin
				rnd_q <= qv[SAMPLE_WIDTH-1:0];
			end
		end
		if (out_load) begin
			res_q.sample_out  <= rnd_q;
			res_q.last_of_run <= last_q;
		end
	end

	rrf_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(MAX_TAPS)) u_hist (
		.clk   (clk),
		.we    (state_q == ST_WRITE),
		.waddr (ptr_q),
		.wdata (sample_q),
		.raddr (rd_q),
		.rdata (hist_rd)
	);

	rrf_ram #(.WIDTH(COEF_WIDTH), .DEPTH(MAX_TAPS)) u_coef (
		.clk   (clk),
		.we    (accept && (command_t'(item.command) == CMD_COEF)),
		.waddr (item.coef_index[TAP_AW-1:0]),
		.wdata (item.coef_value),
		.raddr (tap_q[TAP_AW-1:0]),
		.rdata (coef_rd)
	);

	assign result_valid = res_valid_q;
	assign result       = res_q;

	a_ptr_in_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (9'(ptr_q) < len_q))
		else $error("history pointer outside ring");

	a_tap_range: assert property (@(posedge clk) disable iff (!arst_n)
		issue |-> (tap_q < TAP_CW'(MAX_TAPS)))
		else $error("tap index beyond coefficient store");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && result_stall) |=> (res_q == $past(res_q)))
		else $error("pending result overwritten");

	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> (len_q != '0))
		else $error("ring length is zero");

endmodule
